FILE: src/mqpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqpd_pkg
// Shared types and codes for the bounded deque bank.
// ----------------------------------------------------------------------------
package mqpd_pkg;

    // Request kind carried on the req_type field
    typedef enum logic {
        REQ_ADD    = 1'b0,
        REQ_REMOVE = 1'b1
    } req_type_t;

    // Result codes returned with every transfer on the result channel
    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2
    } result_code_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch request, read queue pointer and count
        logic commit;   // update queue state, load result registers
    } dp_cmd_t;

endpackage : mqpd_pkg
`default_nettype wire

FILE: src/mqpd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqpd_ctrl
// Two-state request sequencer and result-valid tracking.
// ----------------------------------------------------------------------------
module mqpd_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mqpd_pkg::dp_cmd_t     cmd
);
    import mqpd_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the new result
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule : mqpd_ctrl
`default_nettype wire

FILE: src/mqpd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqpd_datapath
// Queue pointer/count store, entry store and result registers.
// ----------------------------------------------------------------------------
module mqpd_datapath #(
    parameter int NUM_QUEUES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  mqpd_pkg::dp_cmd_t      cmd,
    input  wire logic              s_req_type,
    input  wire logic [4:0]        s_queue_select,
    input  wire logic [15:0]       s_item_id,
    input  wire logic              s_urgent,
    output logic [1:0]             m_result_code,
    output logic [15:0]            m_out_id,
    output logic                   m_out_urgent
);
    import mqpd_pkg::*;

    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int EW    = ID_WIDTH + 1;

    localparam logic [HW-1:0] HeadLast = HW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CountMax = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   DepthW   = (CW + 1)'(QUEUE_DEPTH);

    // Per-queue pointer and count store, valid bit means written since reset
    logic [HW-1:0]         head_mem  [NUM_QUEUES];
    logic [CW-1:0]         count_mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] qvalid_reg;

    // Entry store: {urgent, id}, undefined until written
    logic [EW-1:0]         entry_mem [SLOTS];

    // Captured request
    logic                  remove_reg;
    logic [QW-1:0]         qidx_reg;
    logic                  in_range_reg;
    logic [ID_WIDTH-1:0]   id_reg;
    logic                  urgent_reg;
    logic [HW-1:0]         head_rd_reg;
    logic [CW-1:0]         count_rd_reg;
    logic                  qvalid_rd_reg;

    // Result registers
    result_code_t          code_reg;
    logic                  hit_reg;
    logic [EW-1:0]         rd_data_reg;

    logic [QW-1:0]         qidx_in;
    logic [63:0]           id_wide_in;
    logic [63:0]           id_wide_out;
    logic [HW-1:0]         head_cur;
    logic [CW-1:0]         count_cur;
    logic                  full;
    logic                  empty;
    logic                  add_ok;
    logic                  rem_ok;
    logic [HW-1:0]         head_dec;
    logic [HW-1:0]         head_inc;
    logic [CW:0]           tail_sum;
    logic [HW-1:0]         tail_slot;
    logic [HW-1:0]         slot;
    logic [AW-1:0]         addr;
    logic [HW-1:0]         head_new;
    logic [CW-1:0]         count_new;
    result_code_t          code_new;

    assign qidx_in    = QW'(s_queue_select);
    assign id_wide_in = 64'(s_item_id);

    // Capture the request and read the queue's pointer and count
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            remove_reg    <= s_req_type;
            qidx_reg      <= qidx_in;
            in_range_reg  <= (32'(s_queue_select) < 32'(NUM_QUEUES));
            id_reg        <= id_wide_in[ID_WIDTH-1:0];
            urgent_reg    <= s_urgent;
            head_rd_reg   <= head_mem[qidx_in];
            count_rd_reg  <= count_mem[qidx_in];
            qvalid_rd_reg <= qvalid_reg[qidx_in];
        end
    end

    // A queue never written since reset reads as empty with head zero
    assign head_cur  = qvalid_rd_reg ? head_rd_reg  : '0;
    assign count_cur = qvalid_rd_reg ? count_rd_reg : '0;

    assign full   = (count_cur >= CountMax);
    assign empty  = (count_cur == '0);
    assign add_ok = (remove_reg == REQ_ADD)    && in_range_reg && !full;
    assign rem_ok = (remove_reg == REQ_REMOVE) && in_range_reg && !empty;

    assign head_dec  = (head_cur == '0) ? HeadLast : head_cur - HW'(1);
    assign head_inc  = (head_cur == HeadLast) ? '0 : head_cur + HW'(1);
    assign tail_sum  = (CW + 1)'(head_cur) + (CW + 1)'(count_cur);
    assign tail_slot = (tail_sum >= DepthW) ? HW'(tail_sum - DepthW) : HW'(tail_sum);

    always_comb begin
        if (remove_reg == REQ_REMOVE) begin
            slot      = head_cur;
            head_new  = head_inc;
            count_new = count_cur - CW'(1);
        end else if (urgent_reg) begin
            slot      = head_dec;
            head_new  = head_dec;
            count_new = count_cur + CW'(1);
        end else begin
            slot      = tail_slot;
            head_new  = head_cur;
            count_new = count_cur + CW'(1);
        end

        if (remove_reg == REQ_REMOVE) begin
            code_new = rem_ok ? RES_OK : RES_EMPTY;
        end else begin
            code_new = add_ok ? RES_OK : RES_FULL;
        end
    end

    assign addr = AW'(AW'(qidx_reg) * AW'(QUEUE_DEPTH)) + AW'(slot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qvalid_reg <= '0;
        end else if (cmd.commit && (add_ok || rem_ok)) begin
            qvalid_reg[qidx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && (add_ok || rem_ok)) begin
            head_mem[qidx_reg]  <= head_new;
            count_mem[qidx_reg] <= count_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && add_ok) begin
            entry_mem[addr] <= {urgent_reg, id_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            rd_data_reg <= entry_mem[addr];
            hit_reg     <= rem_ok;
            code_reg    <= code_new;
        end
    end

    assign id_wide_out   = 64'(rd_data_reg[ID_WIDTH-1:0]);
    assign m_result_code = code_reg;
    assign m_out_id      = hit_reg ? id_wide_out[15:0] : '0;
    assign m_out_urgent  = hit_reg ? rd_data_reg[EW-1] : 1'b0;

`ifndef SYNTH
    // A stored count never exceeds the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (count_cur <= CountMax))
        else $error("queue count above depth");

    // A committed add never lands in a queue that was already full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && add_ok) |-> (count_new <= CountMax) && (count_new != '0))
        else $error("add committed on a full queue");

    // Any result other than a successful remove reports a zero identifier and flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !rem_ok) |=> (m_out_id == '0) && !m_out_urgent)
        else $error("nonzero payload on a refused or add result");

    // A successful commit marks its queue as written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (add_ok || rem_ok)) |=> qvalid_reg[$past(qidx_reg)])
        else $error("queue valid bit not set after update");
`endif

endmodule : mqpd_datapath
`default_nettype wire

FILE: src/multi_queue_priority_deque_top.sv
`default_nettype none
// An accepted request moves to the execute state and commits once the result register
//   is free or drained; no new request is accepted until then, as the read-modify-write
//   of the selected queue's head pointer and fill count reads at accept and writes at commit.
// A finished result waits in the output register while the next request is accepted.
// Reset (aresetn low, synchronous): clears the sequencer, result valid and the
//   per-queue written bits; the entry store is not cleared.
// ----------------------------------------------------------------------------
// multi_queue_priority_deque_top
// Bank of bounded queues, one per class. Adds go to the tail, or to the head
// when urgent; removes pop the head. Full and empty requests are flagged.
// ----------------------------------------------------------------------------
module multi_queue_priority_deque_top #(
    parameter int NUM_QUEUES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [4:0]  s_queue_select,
    input  wire logic [15:0] s_item_id,
    input  wire logic        s_urgent,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_code,
    output logic [15:0]      m_out_id,
    output logic             m_out_urgent
);
    import mqpd_pkg::*;

    dp_cmd_t cmd;

    // Sequencer: accepts a transfer in idle, commits it once the result
    // register is free or being drained in the same cycle.
    mqpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath: pointer/count store with written bits, circular entry store
    // per queue, and the result registers that feed the m_ payload.
    mqpd_datapath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_req_type     (s_req_type),
        .s_queue_select (s_queue_select),
        .s_item_id      (s_item_id),
        .s_urgent       (s_urgent),
        .m_result_code  (m_result_code),
        .m_out_id       (m_out_id),
        .m_out_urgent   (m_out_urgent)
    );

endmodule : multi_queue_priority_deque_top
`default_nettype wire
